// File: rtl/fst_pkg.sv
// Shared types, constants and codes for the first come first served scheduler.
package fst_pkg;

	// Store capacity and derived widths
	localparam int MAX_JOBS = 32;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int FIELD_W  = 16;
	localparam int TIME_W   = 24;

	// One job as loaded on the input channel
	typedef struct packed {
		logic [FIELD_W-1:0] job_id;
		logic [FIELD_W-1:0] arrival;
		logic [FIELD_W-1:0] burst;
		logic               final_job;
	} fst_job_t;

	// One scheduled job on the result channel
	typedef struct packed {
		logic [FIELD_W-1:0] out_job_id;
		logic [FIELD_W-1:0] out_arrival;
		logic [FIELD_W-1:0] out_burst;
		logic [TIME_W-1:0]  start_time;
		logic [TIME_W-1:0]  finish_time;
		logic [TIME_W-1:0]  wait_time;
		logic               overflowed;
		logic               last_result;
	} fst_result_t;

	// One entry of the job store
	typedef struct packed {
		logic [FIELD_W-1:0] job_id;
		logic [FIELD_W-1:0] arrival;
		logic [FIELD_W-1:0] burst;
	} fst_entry_t;

	// Store port request: one write and one read address per cycle
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		fst_entry_t       wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} fst_mem_req_t;

	// Shared arithmetic unit operations
	typedef enum logic [1:0] {
		ALU_GT,
		ALU_MAX,
		ALU_ADD,
		ALU_SUB
	} fst_alu_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_CMP,
		ST_SRD,
		ST_SMAX,
		ST_SADD,
		ST_SSUB,
		ST_OUT
	} fst_state_t;

endpackage

// File: rtl/fcfs_schedule_times_unit.sv
// Top level: job loader with stable insertion and first come first served scan.
//
//  channel  | valid / ready              | payload        | direction
//  ---------+----------------------------+----------------+----------
//  jobs     | job_valid / job_ready      | job (fst_job_t)    | in
//  results  | result_valid / result_ready| result (fst_result_t) | out
//
// A stored job is inserted from the end of the set: each stored job with a later
// arrival is read and moved up one place, and the new job is written where the
// scan stops; a dropped job is only accepted. A final job then emits one result
// per stored job, held until taken; the shared unit does max, add and subtract
// in turn. job_ready is low from acceptance until the item's work and all its
// results are done. Reset empties the set; store contents are left as they are.
module fcfs_schedule_times_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  fst_pkg::fst_job_t    job,
	output logic                 result_valid,
	input  logic                 result_ready,
	output fst_pkg::fst_result_t result
);

	localparam int CW = fst_pkg::CNT_W;
	localparam int IW = fst_pkg::IDX_W;
	localparam int TW = fst_pkg::TIME_W;
	localparam int FW = fst_pkg::FIELD_W;

	fst_pkg::fst_state_t   state_q, state_d;
	fst_pkg::fst_mem_req_t mem_req;
	fst_pkg::fst_entry_t   rd_data;
	fst_pkg::fst_entry_t   new_q;
	fst_pkg::fst_alu_op_t  alu_op;
	fst_pkg::fst_result_t  result_q;
	logic [TW-1:0]         alu_a, alu_b, alu_y;
	logic [CW-1:0]         count_q, pos_q, k_q;
	logic                  ovf_q, fin_q, out_valid_q;
	logic [TW-1:0]         prev_q, start_q, finish_q;
	logic                  job_beat, res_beat, has_room, later, last_k;

	fst_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	fst_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	assign job_beat = job_valid && job_ready;
	assign res_beat = out_valid_q && result_ready;
	assign has_room = (count_q < CW'(fst_pkg::MAX_JOBS));
	assign later    = alu_y[0];
	assign last_k   = ((k_q + CW'(1)) == count_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fst_pkg::ST_IDLE: begin
				if (job_beat) begin
					if (has_room) begin
						state_d = fst_pkg::ST_INS;
					end else if (job.final_job) begin
						state_d = fst_pkg::ST_SRD;
					end
				end
			end
			fst_pkg::ST_INS: begin
				if (pos_q != '0) begin
					state_d = fst_pkg::ST_CMP;
				end else begin
					state_d = fin_q ? fst_pkg::ST_SRD : fst_pkg::ST_IDLE;
				end
			end
			fst_pkg::ST_CMP: begin
				if (later) begin
					state_d = fst_pkg::ST_INS;
				end else begin
					state_d = fin_q ? fst_pkg::ST_SRD : fst_pkg::ST_IDLE;
				end
			end
			fst_pkg::ST_SRD:  state_d = fst_pkg::ST_SMAX;
			fst_pkg::ST_SMAX: state_d = fst_pkg::ST_SADD;
			fst_pkg::ST_SADD: state_d = fst_pkg::ST_SSUB;
			fst_pkg::ST_SSUB: state_d = fst_pkg::ST_OUT;
			fst_pkg::ST_OUT: begin
				if (res_beat) begin
					state_d = result_q.last_result ? fst_pkg::ST_IDLE : fst_pkg::ST_SRD;
				end
			end
			default: state_d = fst_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: store port, shared unit operands, ready
	always_comb begin
		mem_req         = '0;
		mem_req.wr_addr = pos_q[IW-1:0];
		mem_req.wr_data = new_q;
		mem_req.rd_addr = k_q[IW-1:0];
		alu_op          = fst_pkg::ALU_GT;
		alu_a           = {{(TW-FW){1'b0}}, rd_data.arrival};
		alu_b           = {{(TW-FW){1'b0}}, new_q.arrival};
		job_ready       = 1'b0;
		unique case (state_q)
			fst_pkg::ST_IDLE: job_ready = 1'b1;
			fst_pkg::ST_INS: begin
				if (pos_q != '0) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = IW'(pos_q - CW'(1));
				end else begin
					mem_req.wr_en = 1'b1;
				end
			end
			fst_pkg::ST_CMP: begin
				// stored job arriving later moves up one place
				mem_req.wr_en = 1'b1;
				if (later) begin
					mem_req.wr_data = rd_data;
				end
			end
			fst_pkg::ST_SRD: mem_req.rd_en = 1'b1;
			fst_pkg::ST_SMAX: begin
				alu_op = fst_pkg::ALU_MAX;
				alu_a  = prev_q;
				alu_b  = {{(TW-FW){1'b0}}, rd_data.arrival};
			end
			fst_pkg::ST_SADD: begin
				alu_op = fst_pkg::ALU_ADD;
				alu_a  = start_q;
				alu_b  = {{(TW-FW){1'b0}}, rd_data.burst};
			end
			fst_pkg::ST_SSUB: begin
				alu_op = fst_pkg::ALU_SUB;
				alu_a  = start_q;
				alu_b  = {{(TW-FW){1'b0}}, rd_data.arrival};
			end
			fst_pkg::ST_OUT: ;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fst_pkg::ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			k_q         <= '0;
			fin_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				fst_pkg::ST_IDLE: begin
					if (job_beat) begin
						fin_q <= job.final_job;
						pos_q <= count_q;
						k_q   <= '0;
						if (!has_room) begin
							ovf_q <= 1'b1;
						end
					end
				end
				fst_pkg::ST_INS: begin
					if (pos_q == '0) begin
						count_q <= count_q + CW'(1);
					end
				end
				fst_pkg::ST_CMP: begin
					if (later) begin
						pos_q <= pos_q - CW'(1);
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				fst_pkg::ST_SSUB: out_valid_q <= 1'b1;
				fst_pkg::ST_OUT: begin
					if (res_beat) begin
						out_valid_q <= 1'b0;
						if (result_q.last_result) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							k_q <= k_q + CW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			fst_pkg::ST_IDLE: begin
				if (job_beat) begin
					new_q.job_id  <= job.job_id;
					new_q.arrival <= job.arrival;
					new_q.burst   <= job.burst;
					prev_q        <= '0;
				end
			end
			fst_pkg::ST_SMAX: start_q <= alu_y;
			fst_pkg::ST_SADD: begin
				finish_q <= alu_y;
				prev_q   <= alu_y;
			end
			fst_pkg::ST_SSUB: begin
				result_q.out_job_id  <= rd_data.job_id;
				result_q.out_arrival <= rd_data.arrival;
				result_q.out_burst   <= rd_data.burst;
				result_q.start_time  <= start_q;
				result_q.finish_time <= finish_q;
				result_q.wait_time   <= alu_y;
				result_q.overflowed  <= ovf_q;
				result_q.last_result <= last_k;
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

	// A result is only ever shown from the output state
	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == fst_pkg::ST_OUT))
		else $error("result valid outside output state");

	// The set never holds more than the store capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(fst_pkg::MAX_JOBS))
		else $error("job count beyond capacity");

	// No job is taken while a result is pending
	a_no_load_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> !out_valid_q)
		else $error("job ready while result pending");

	// The last result empties the set and clears the flag
	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(res_beat && result_q.last_result) |=> (count_q == '0 && !ovf_q))
		else $error("set not cleared after last result");

	// A final load that was stored leads to scheduling
	a_final_sched: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fst_pkg::ST_CMP && !later && fin_q) |=> (state_q == fst_pkg::ST_SRD))
		else $error("final job did not start the schedule");

endmodule

// File: rtl/fst_alu.sv
// Shared compare / max / add / subtract unit on time-width operands.
module fst_alu (
	input  fst_pkg::fst_alu_op_t        op,
	input  logic [fst_pkg::TIME_W-1:0] a,
	input  logic [fst_pkg::TIME_W-1:0] b,
	output logic [fst_pkg::TIME_W-1:0] y
);

	logic a_gt_b;

	assign a_gt_b = (a > b);

	// Operation select
	always_comb begin
		unique case (op)
			fst_pkg::ALU_GT:  y = {{(fst_pkg::TIME_W-1){1'b0}}, a_gt_b};
			fst_pkg::ALU_MAX: y = a_gt_b ? a : b;
			fst_pkg::ALU_ADD: y = a + b;
			fst_pkg::ALU_SUB: y = a - b;
			default:          y = '0;
		endcase
	end

endmodule

// File: rtl/fst_store.sv
// Job store: one write port and one registered read port.
module fst_store (
	input  logic                  clk,
	input  fst_pkg::fst_mem_req_t req,
	output fst_pkg::fst_entry_t   rd_data
);

	fst_pkg::fst_entry_t mem [fst_pkg::MAX_JOBS];

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for fcfs_schedule_times_unit: job sets in, schedules checked against a predictor.

// Scoreboard: keeps its own sorted job set and the queue of schedule beats still due
class fcfs_scoreboard;
	fst_pkg::fst_entry_t  job_set[$];
	bit                   jobs_dropped;
	fst_pkg::fst_result_t sched_due[$];
	int unsigned          errors;

	function new();
		jobs_dropped = 1'b0;
		errors       = 0;
	endfunction

	function int pending();
		return sched_due.size();
	endfunction

	// Accepted job beat: stable insert by arrival, build the schedule on the final job
	function void note_job(fst_pkg::fst_job_t j);
		fst_pkg::fst_entry_t        e;
		fst_pkg::fst_result_t       r;
		int                         pos;
		logic [fst_pkg::TIME_W-1:0] prev_finish;
		logic [fst_pkg::TIME_W-1:0] arr_t;
		logic [fst_pkg::TIME_W-1:0] start;
		if (job_set.size() < fst_pkg::MAX_JOBS) begin
			pos = job_set.size();
			while (pos > 0 && job_set[pos-1].arrival > j.arrival)
				pos--;
			e.job_id  = j.job_id;
			e.arrival = j.arrival;
			e.burst   = j.burst;
			job_set.insert(pos, e);
		end else begin
			jobs_dropped = 1'b1;
		end
		if (!j.final_job)
			return;
		prev_finish = '0;
		foreach (job_set[k]) begin
			arr_t         = fst_pkg::TIME_W'(job_set[k].arrival);
			start         = (prev_finish > arr_t) ? prev_finish : arr_t;
			r.out_job_id  = job_set[k].job_id;
			r.out_arrival = job_set[k].arrival;
			r.out_burst   = job_set[k].burst;
			r.start_time  = start;
			r.finish_time = start + fst_pkg::TIME_W'(job_set[k].burst);
			r.wait_time   = start - arr_t;
			r.overflowed  = jobs_dropped;
			r.last_result = (k == job_set.size() - 1);
			sched_due.push_back(r);
			prev_finish   = r.finish_time;
		end
		job_set.delete();
		jobs_dropped = 1'b0;
	endfunction

	function void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Accepted result beat: compare with the oldest due entry
	function void check_result(fst_pkg::fst_result_t got);
		fst_pkg::fst_result_t want;
		if (sched_due.size() == 0) begin
			$error("result beat with nothing due: job id %0d", got.out_job_id);
			errors++;
			return;
		end
		want = sched_due.pop_front();
		check_field("out_job_id",  want.out_job_id,  got.out_job_id);
		check_field("out_arrival", want.out_arrival, got.out_arrival);
		check_field("out_burst",   want.out_burst,   got.out_burst);
		check_field("start_time",  want.start_time,  got.start_time);
		check_field("finish_time", want.finish_time, got.finish_time);
		check_field("wait_time",   want.wait_time,   got.wait_time);
		check_field("overflowed",  want.overflowed,  got.overflowed);
		check_field("last_result", want.last_result, got.last_result);
	endfunction
endclass

module tb;

	localparam int RAND_ITEMS  = 90;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;

	typedef enum int {
		SPREAD_FULL,
		SPREAD_TIES,
		SPREAD_TOP,
		SPREAD_LOW
	} spread_t;

	logic                 clk;
	logic                 arst_n;
	logic                 job_valid;
	logic                 job_ready;
	fst_pkg::fst_job_t    job;
	logic                 result_valid;
	logic                 result_ready;
	fst_pkg::fst_result_t result;

	fcfs_scoreboard sb;
	bit             steady;
	bit             hold_req;
	int             rand_items;
	int unsigned    quiet_cycles;

	fcfs_schedule_times_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.job          (job),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one job beat, sometimes after a random gap, and wait for acceptance
	task automatic send_job(input logic [15:0] id, input logic [15:0] arr,
	                        input logic [15:0] bst, input logic fin);
		fst_pkg::fst_job_t j;
		j.job_id    = id;
		j.arrival   = arr;
		j.burst     = bst;
		j.final_job = fin;
		if (!steady && $urandom_range(99) < 36) begin
			job_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 36);
		end
		job_valid <= 1'b1;
		job       <= j;
		do @(posedge clk); while (!job_ready);
	endtask

	// Lower valid and hold until every due result beat has gone through
	task automatic wait_drained();
		job_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One random job set; the final flag sits on the last job
	task automatic send_set(input int n);
		spread_t     spread;
		int          burst_mode;
		logic [15:0] arr;
		logic [15:0] bst;
		spread     = spread_t'($urandom_range(3));
		burst_mode = $urandom_range(2);
		for (int i = 0; i < n; i++) begin
			case (spread)
				SPREAD_FULL: arr = 16'($urandom);
				SPREAD_TIES: arr = 16'($urandom_range(7));
				SPREAD_TOP:  arr = 16'hFFFF - 16'($urandom_range(15));
				default:     arr = 16'($urandom_range(1023));
			endcase
			if (burst_mode == 0)
				bst = 16'($urandom);
			else if (burst_mode == 1)
				bst = 16'($urandom_range(3));
			else
				bst = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(200));
			rand_items++;
			steady = (rand_items >= 40 && rand_items < 75);
			send_job(16'($urandom), arr, bst, i == n - 1);
		end
	endtask

	// Receiver: random back-pressure, one long hold-off when asked
	initial begin
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_ready <= steady || ($urandom_range(99) >= 36);
		end
	end

	// Beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(result);
			if (job_valid && job_ready)
				sb.note_job(job);
			if ((job_valid && job_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** fcfs_schedule_times_unit: FAILED **");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		int n;
		int set_idx;
		sb           = new();
		steady       = 1'b0;
		hold_req     = 1'b0;
		rand_items   = 0;
		quiet_cycles = 0;
		arst_n       <= 1'b0;
		job_valid    <= 1'b0;
		job          <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-job sets at the field extremes
		send_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_job(16'h0000, 16'h0000, 16'h0000, 1'b1);
		// Out-of-order arrivals with ties: stable order, waits carried over
		send_job(16'd1, 16'd100,   16'd5,     1'b0);
		send_job(16'd2, 16'd50,    16'd0,     1'b0);
		send_job(16'd3, 16'd100,   16'd7,     1'b0);
		send_job(16'd4, 16'd0,     16'hFFFF,  1'b0);
		send_job(16'd5, 16'd50,    16'd3,     1'b0);
		send_job(16'd6, 16'hFFFF,  16'd1,     1'b0);
		send_job(16'd7, 16'd0,     16'd2,     1'b1);
		// Ascending with an idle gap: a job starts at its own arrival
		send_job(16'd10, 16'd10, 16'd5,   1'b0);
		send_job(16'd11, 16'd40, 16'd5,   1'b0);
		send_job(16'd12, 16'd41, 16'd100, 1'b0);
		send_job(16'd13, 16'd60, 16'd1,   1'b1);
		// Longest bursts piled up from time zero
		send_job(16'd20, 16'd0, 16'hFFFF, 1'b0);
		send_job(16'd21, 16'd0, 16'hFFFF, 1'b0);
		send_job(16'd22, 16'd0, 16'hFFFF, 1'b0);
		send_job(16'd23, 16'd0, 16'hFFFF, 1'b1);
		wait_drained();

		// Random sets; the first runs into a long receiver hold-off
		hold_req = 1'b1;
		set_idx  = 0;
		while (rand_items < RAND_ITEMS) begin
			case (set_idx)
				0:       n = 4 + $urandom_range(4);
				1:       n = fst_pkg::MAX_JOBS + 1;
				3:       n = fst_pkg::MAX_JOBS;
				default: n = 1 + $urandom_range(7);
			endcase
			send_set(n);
			set_idx++;
		end
		steady = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("** fcfs_schedule_times_unit: PASSED **");
		else
			$display("** fcfs_schedule_times_unit: FAILED **");
		$finish;
	end

endmodule

// File: fcfs_schedule_times_unit.f
rtl/fst_pkg.sv
rtl/fst_alu.sv
rtl/fst_store.sv
rtl/fcfs_schedule_times_unit.sv
sim/tb.sv
